>>> rtl/poi_pkg.sv
package poi_pkg;

   localparam int CORDIC_STAGES = 24;

   localparam logic [19:0] USEC      = 20'd1000000;
   localparam logic [19:0] USEC_HALF = 20'd500000;
   localparam logic [31:0] TURN_C    = 32'd683565276;
   localparam logic [31:0] INV_GAIN  = 32'h9B74EDA8;

   localparam logic signed [65:0] POS_MAX = 66'sh0_0000_7FFF_FFFF_FFFF;
   localparam logic signed [65:0] POS_MIN = -66'sh0_0000_8000_0000_0000;

   function automatic logic [31:0] atan_bam(input logic [4:0] idx);
      logic [31:0] v;
      unique case (idx)
         5'd0:    v = 32'h20000000;
         5'd1:    v = 32'h12E4051E;
         5'd2:    v = 32'h09FB385B;
         5'd3:    v = 32'h051111D4;
         5'd4:    v = 32'h028B0D43;
         5'd5:    v = 32'h0145D7E1;
         5'd6:    v = 32'h00A2F61E;
         5'd7:    v = 32'h00517C55;
         5'd8:    v = 32'h0028BE53;
         5'd9:    v = 32'h00145F2F;
         5'd10:   v = 32'h000A2F98;
         5'd11:   v = 32'h000517CC;
         5'd12:   v = 32'h00028BE6;
         5'd13:   v = 32'h000145F3;
         5'd14:   v = 32'h0000A2FA;
         5'd15:   v = 32'h0000517D;
         5'd16:   v = 32'h000028BE;
         5'd17:   v = 32'h0000145F;
         5'd18:   v = 32'h00000A30;
         5'd19:   v = 32'h00000518;
         5'd20:   v = 32'h0000028C;
         5'd21:   v = 32'h00000146;
         5'd22:   v = 32'h000000A3;
         5'd23:   v = 32'h00000051;
         5'd24:   v = 32'h00000029;
         5'd25:   v = 32'h00000014;
         5'd26:   v = 32'h0000000A;
         5'd27:   v = 32'h00000005;
         5'd28:   v = 32'h00000003;
         5'd29:   v = 32'h00000001;
         5'd30:   v = 32'h00000001;
         default: v = 32'h00000000;
      endcase
      return v;
   endfunction

   function automatic logic [31:0] mag32(input logic [31:0] v);
      return v[31] ? (32'd0 - v) : v;
   endfunction

   function automatic logic [63:0] mag64(input logic [63:0] v);
      return v[63] ? (64'd0 - v) : v;
   endfunction

endpackage

>>> rtl/poi_mul.sv
module poi_mul (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] opa,
   input  logic [31:0] opb,
   output logic        done,
   output logic [63:0] prod
);

   localparam logic [4:0] LAST = 5'd31;

   logic        busy_ff;
   logic        done_ff;
   logic [4:0]  cnt_ff;
   logic [63:0] a_ff;
   logic [31:0] b_ff;
   logic [63:0] acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            a_ff    <= opa;
            b_ff    <= opb;
            acc_ff  <= '0;
         end else if (busy_ff) begin
            acc_ff <= acc_ff + (b_ff[0] ? a_ff : 64'd0);
            a_ff   <= {a_ff[62:0], 1'b0};
            b_ff   <= {1'b0, b_ff[31:1]};
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign prod = acc_ff;

endmodule

>>> rtl/poi_div.sv
module poi_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] num,
   output logic        done,
   output logic [63:0] quo,
   output logic [19:0] rem
);

   localparam logic [5:0] LAST = 6'd63;

   logic        busy_ff;
   logic        done_ff;
   logic [5:0]  cnt_ff;
   logic [63:0] n_ff;
   logic [19:0] r_ff;
   logic [20:0] trial;
   logic        ge;
   logic [20:0] diff;

   always_comb begin
      trial = {r_ff, n_ff[63]};
      ge    = trial >= {1'b0, poi_pkg::USEC};
      diff  = trial - {1'b0, poi_pkg::USEC};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            n_ff    <= num;
            r_ff    <= '0;
         end else if (busy_ff) begin
            r_ff   <= ge ? diff[19:0] : trial[19:0];
            n_ff   <= {n_ff[62:0], ge};
            cnt_ff <= cnt_ff + 6'd1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done = done_ff;
   assign quo  = n_ff;
   assign rem  = r_ff;

endmodule

>>> rtl/poi_cordic.sv
module poi_cordic (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic signed [63:0] x_init,
   input  logic signed [63:0] y_init,
   input  logic [31:0]        ang,
   output logic               done,
   output logic signed [63:0] x_out,
   output logic signed [63:0] y_out
);

   localparam logic [4:0] LAST = 5'(poi_pkg::CORDIC_STAGES - 1);
   localparam logic signed [33:0] QUARTER = 34'sh040000000;
   localparam logic signed [33:0] HALFT   = 34'sh080000000;

   logic               busy_ff;
   logic               done_ff;
   logic [4:0]         cnt_ff;
   logic signed [63:0] x_ff;
   logic signed [63:0] y_ff;
   logic signed [33:0] z_ff;
   logic signed [33:0] z0;
   logic               flip;
   logic signed [63:0] xs;
   logic signed [63:0] ys;
   logic signed [33:0] at;

   always_comb begin
      z0   = {{2{ang[31]}}, ang};
      flip = (z0 > QUARTER) || (z0 < -QUARTER);
      xs   = x_ff >>> cnt_ff;
      ys   = y_ff >>> cnt_ff;
      at   = {2'b00, poi_pkg::atan_bam(cnt_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && !start && (cnt_ff == LAST);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
            if (flip) begin
               x_ff <= -x_init;
               y_ff <= -y_init;
               z_ff <= (z0 > 34'sd0) ? (z0 - HALFT) : (z0 + HALFT);
            end else begin
               x_ff <= x_init;
               y_ff <= y_init;
               z_ff <= z0;
            end
         end else if (busy_ff) begin
            if (z_ff >= 34'sd0) begin
               x_ff <= x_ff - ys;
               y_ff <= y_ff + xs;
               z_ff <= z_ff - at;
            end else begin
               x_ff <= x_ff + ys;
               y_ff <= y_ff - xs;
               z_ff <= z_ff + at;
            end
            cnt_ff <= cnt_ff + 5'd1;
            if (cnt_ff == LAST) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign done  = done_ff;
   assign x_out = x_ff;
   assign y_out = y_ff;

endmodule

>>> rtl/planar_odometry_integrator_core.sv
// velocity item: multiplications, divisions and a cordic rotation run one after another to the result;
// the time is spent in the bit-serial multiplier, the radix-2 divider and the cordic loop
// load-pose item: pose and heading registers written when the item is accepted, no result
// throughput: one item at a time; next item taken the cycle the result appears, a stall delays it
// reset (synchronous): pose, heading, previous stamp and mode cleared, no result pending
module planar_odometry_integrator_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_stamp_us,
   input  logic signed [31:0] req_vel_fwd,
   input  logic signed [31:0] req_vel_side,
   input  logic signed [31:0] req_yaw_rate,
   input  logic signed [47:0] req_set_x,
   input  logic signed [47:0] req_set_y,
   input  logic [31:0] req_set_heading,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_out_stamp,
   output logic signed [47:0] rsp_pos_x,
   output logic signed [47:0] rsp_pos_y,
   output logic [31:0] rsp_heading,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_integration_mode
);

   typedef enum logic [3:0] {
      S_IDLE, S_MF, S_DF, S_MS, S_DS, S_MW, S_DW, S_MQ, S_MR, S_DR,
      S_ROT, S_GXH, S_GXL, S_GYH, S_GYL, S_OUT
   } state_type;

   state_type state_ff;
   logic      launch_ff;
   logic      launch_in;
   logic      mode_ff;

   logic signed [47:0] est_x_ff;
   logic signed [47:0] est_y_ff;
   logic [31:0]        est_h_ff;
   logic [31:0]        prev_ff;

   logic [31:0] stamp_ff;
   logic [31:0] dt_ff;
   logic [31:0] vf_ff;
   logic [31:0] vs_ff;
   logic [31:0] wz_ff;
   logic [63:0] dx_ff;
   logic [63:0] dy_ff;
   logic [63:0] q_ff;
   logic [19:0] r_ff;
   logic [63:0] qc_ff;
   logic [63:0] f_ff;
   logic [63:0] cx_ff;
   logic [63:0] cy_ff;
   logic [63:0] h_ff;
   logic [63:0] gx_ff;

   logic        rsp_valid_ff;
   logic [31:0] rsp_stamp_ff;
   logic [47:0] rsp_x_ff;
   logic [47:0] rsp_y_ff;
   logic [31:0] rsp_h_ff;

   logic        mul_start;
   logic [63:0] mul_a;
   logic [31:0] mul_b;
   logic        mul_done;
   logic [63:0] mul_p;
   logic        div_start;
   logic [63:0] div_n;
   logic        div_done;
   logic [63:0] div_q;
   logic [19:0] div_r;
   logic        rot_start;
   logic [31:0] rot_ang;
   logic        rot_done;
   logic signed [63:0] rot_x;
   logic signed [63:0] rot_y;

   logic        step_done;
   logic        accept;
   logic        slot_free;
   logic [63:0] fs;
   logic [63:0] fh;
   logic [31:0] dh;
   logic [31:0] hs;
   logic [63:0] mx;
   logic [63:0] my;
   logic [64:0] lo_rnd;
   logic [63:0] g_mag;
   logic [63:0] g_cur;
   logic signed [65:0] sum_x;
   logic signed [65:0] sum_y;
   logic [47:0] new_x;
   logic [47:0] new_y;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      fs      = f_ff + 64'h8000;
      fh      = f_ff + 64'h10000;
      dh      = wz_ff[31] ? (32'd0 - fs[47:16]) : fs[47:16];
      hs      = wz_ff[31] ? (32'd0 - fh[48:17]) : fh[48:17];
      rot_ang = est_h_ff + (mode_ff ? hs : 32'd0);
      mx      = poi_pkg::mag64(cx_ff);
      my      = poi_pkg::mag64(cy_ff);
      lo_rnd  = {1'b0, mul_p} + 65'h80000000;
      g_mag   = h_ff + {31'd0, lo_rnd[64:32]};
      g_cur   = ((state_ff == S_GYL) ? cy_ff[63] : cx_ff[63]) ? (64'd0 - g_mag) : g_mag;
      sum_x   = {{18{est_x_ff[47]}}, est_x_ff} + {{2{gx_ff[63]}}, gx_ff};
      sum_y   = {{18{est_y_ff[47]}}, est_y_ff} + {{2{h_ff[63]}}, h_ff};
      if (sum_x > poi_pkg::POS_MAX) new_x = poi_pkg::POS_MAX[47:0];
      else if (sum_x < poi_pkg::POS_MIN) new_x = poi_pkg::POS_MIN[47:0];
      else new_x = sum_x[47:0];
      if (sum_y > poi_pkg::POS_MAX) new_y = poi_pkg::POS_MAX[47:0];
      else if (sum_y < poi_pkg::POS_MIN) new_y = poi_pkg::POS_MIN[47:0];
      else new_y = sum_y[47:0];
   end

   always_comb begin
      mul_a = '0;
      mul_b = dt_ff;
      unique case (state_ff)
         S_MF:    mul_a = {32'd0, poi_pkg::mag32(vf_ff)};
         S_MS:    mul_a = {32'd0, poi_pkg::mag32(vs_ff)};
         S_MW:    mul_a = {32'd0, poi_pkg::mag32(wz_ff)};
         S_MQ: begin
            mul_a = q_ff;
            mul_b = poi_pkg::TURN_C;
         end
         S_MR: begin
            mul_a = {44'd0, r_ff};
            mul_b = poi_pkg::TURN_C;
         end
         S_GXH: begin
            mul_a = {32'd0, mx[63:32]};
            mul_b = poi_pkg::INV_GAIN;
         end
         S_GXL: begin
            mul_a = {32'd0, mx[31:0]};
            mul_b = poi_pkg::INV_GAIN;
         end
         S_GYH: begin
            mul_a = {32'd0, my[63:32]};
            mul_b = poi_pkg::INV_GAIN;
         end
         S_GYL: begin
            mul_a = {32'd0, my[31:0]};
            mul_b = poi_pkg::INV_GAIN;
         end
         default: mul_a = '0;
      endcase
   end

   always_comb begin
      unique case (state_ff)
         S_DW:    div_n = mul_p;
         default: div_n = mul_p + {44'd0, poi_pkg::USEC_HALF};
      endcase
   end

   always_comb begin
      mul_start = 1'b0;
      div_start = 1'b0;
      rot_start = 1'b0;
      step_done = 1'b0;
      unique case (state_ff)
         S_MF, S_MS, S_MW, S_MQ, S_MR, S_GXH, S_GXL, S_GYH, S_GYL: begin
            mul_start = launch_ff;
            step_done = mul_done;
         end
         S_DF, S_DS, S_DW, S_DR: begin
            div_start = launch_ff;
            step_done = div_done;
         end
         S_ROT: begin
            rot_start = launch_ff;
            step_done = rot_done;
         end
         default: step_done = 1'b0;
      endcase
      launch_in = ((state_ff == S_IDLE) && accept && !req_cmd) ||
                  (step_done && (state_ff != S_GYL));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         launch_ff    <= 1'b0;
         mode_ff      <= 1'b0;
         est_x_ff     <= '0;
         est_y_ff     <= '0;
         est_h_ff     <= '0;
         prev_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         launch_ff <= launch_in;
         if (csr_valid && csr_ready) begin
            mode_ff <= csr_integration_mode;
         end
         if (rsp_valid_ff && !rsp_stall && (state_ff != S_OUT)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  if (req_cmd) begin
                     est_x_ff <= req_set_x;
                     est_y_ff <= req_set_y;
                     est_h_ff <= req_set_heading;
                  end else begin
                     stamp_ff  <= req_stamp_us;
                     dt_ff     <= req_stamp_us - prev_ff;
                     vf_ff     <= req_vel_fwd;
                     vs_ff     <= req_vel_side;
                     wz_ff     <= req_yaw_rate;
                     state_ff  <= S_MF;
                  end
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  est_x_ff     <= new_x;
                  est_y_ff     <= new_y;
                  est_h_ff     <= est_h_ff + dh;
                  prev_ff      <= stamp_ff;
                  rsp_valid_ff <= 1'b1;
                  rsp_stamp_ff <= stamp_ff;
                  rsp_x_ff     <= new_x;
                  rsp_y_ff     <= new_y;
                  rsp_h_ff     <= est_h_ff + dh;
                  state_ff     <= S_IDLE;
               end
            end
            default: begin
               if (step_done) begin
                  unique case (state_ff)
                     S_MF:  state_ff <= S_DF;
                     S_DF: begin
                        dx_ff    <= vf_ff[31] ? (64'd0 - div_q) : div_q;
                        state_ff <= S_MS;
                     end
                     S_MS:  state_ff <= S_DS;
                     S_DS: begin
                        dy_ff    <= vs_ff[31] ? (64'd0 - div_q) : div_q;
                        state_ff <= S_MW;
                     end
                     S_MW:  state_ff <= S_DW;
                     S_DW: begin
                        q_ff     <= div_q;
                        r_ff     <= div_r;
                        state_ff <= S_MQ;
                     end
                     S_MQ: begin
                        qc_ff    <= mul_p;
                        state_ff <= S_MR;
                     end
                     S_MR:  state_ff <= S_DR;
                     S_DR: begin
                        f_ff     <= qc_ff + div_q;
                        state_ff <= S_ROT;
                     end
                     S_ROT: begin
                        cx_ff    <= rot_x;
                        cy_ff    <= rot_y;
                        state_ff <= S_GXH;
                     end
                     S_GXH: begin
                        h_ff     <= mul_p;
                        state_ff <= S_GXL;
                     end
                     S_GXL: begin
                        gx_ff    <= g_cur;
                        state_ff <= S_GYH;
                     end
                     S_GYH: begin
                        h_ff     <= mul_p;
                        state_ff <= S_GYL;
                     end
                     S_GYL: begin
                        h_ff      <= g_cur;
                        state_ff  <= S_OUT;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
         endcase
      end
   end

   poi_mul u_mul (
      .clock (clock),
      .reset (reset),
      .start (mul_start),
      .opa   (mul_a),
      .opb   (mul_b),
      .done  (mul_done),
      .prod  (mul_p)
   );

   poi_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (div_n),
      .done  (div_done),
      .quo   (div_q),
      .rem   (div_r)
   );

   poi_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (rot_start),
      .x_init (dx_ff),
      .y_init (dy_ff),
      .ang    (rot_ang),
      .done   (rot_done),
      .x_out  (rot_x),
      .y_out  (rot_y)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_stamp = rsp_stamp_ff;
   assign rsp_pos_x     = rsp_x_ff;
   assign rsp_pos_y     = rsp_y_ff;
   assign rsp_heading   = rsp_h_ff;

   a_vel_starts: assert property (@(posedge clock) disable iff (reset)
      accept && !req_cmd |=> state_ff == S_MF && launch_ff)
      else $error("velocity item did not start the multiplier");

   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      accept && req_cmd |=> state_ff == S_IDLE)
      else $error("load item left idle");

   a_one_unit: assert property (@(posedge clock) disable iff (reset)
      !(mul_done && div_done) && !(mul_done && rot_done) && !(div_done && rot_done))
      else $error("two arithmetic units finished together");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_pos_x) && $stable(rsp_heading))
      else $error("pending result overwritten");

endmodule
